// ===== rtl/core/mhti_pkg.sv =====
// Shared types, marker codes and the standard Huffman table ROM for the DHT inserter.
`timescale 1ns / 1ps
`default_nettype none

package mhti_pkg;

  localparam int TableBytesDef     = 420;
  localparam int BytesPerResultDef = 8;
  localparam int QueueDepth        = 4;
  localparam int DhtRomLen         = 420;
  localparam int OutBytes          = 8;

  localparam logic [7:0] ByteFF     = 8'hFF;
  localparam logic [7:0] ByteZero   = 8'h00;
  localparam logic [7:0] MarkSos    = 8'hDA;
  localparam logic [7:0] MarkDht    = 8'hC4;
  localparam logic [7:0] MarkRstLo  = 8'hD0;
  localparam logic [7:0] MarkSoi    = 8'hD8;
  localparam logic [7:0] MarkEoi    = 8'hD9;

  // One classified input beat: an optional table insertion followed by up to two bytes.
  typedef struct packed {
    logic       ins_table;
    logic [1:0] lit_n;
    logic [7:0] lit0;
    logic [7:0] lit1;
    logic       last;
    logic       err;
  } mhti_cmd_t;

  // Standard luminance/chrominance DHT segment, first byte in the top bits.
  localparam logic [DhtRomLen*8-1:0] DHT_ROM = {
    8'hFF,8'hC4,8'h01,8'hA2,8'h00,8'h00,8'h01,8'h05,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h02,
    8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0A,8'h0B,8'h01,8'h00,8'h03,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,
    8'h0A,8'h0B,8'h10,8'h00,8'h02,8'h01,8'h03,8'h03,8'h02,8'h04,8'h03,8'h05,
    8'h05,8'h04,8'h04,8'h00,8'h00,8'h01,8'h7D,8'h01,8'h02,8'h03,8'h00,8'h04,
    8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,8'h61,8'h07,8'h22,
    8'h71,8'h14,8'h32,8'h81,8'h91,8'hA1,8'h08,8'h23,8'h42,8'hB1,8'hC1,8'h15,
    8'h52,8'hD1,8'hF0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0A,8'h16,8'h17,
    8'h18,8'h19,8'h1A,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2A,8'h34,8'h35,8'h36,
    8'h37,8'h38,8'h39,8'h3A,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,
    8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5A,8'h63,8'h64,8'h65,8'h66,
    8'h67,8'h68,8'h69,8'h6A,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7A,
    8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8A,8'h92,8'h93,8'h94,8'h95,
    8'h96,8'h97,8'h98,8'h99,8'h9A,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,
    8'hA9,8'hAA,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBA,8'hC2,
    8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hCA,8'hD2,8'hD3,8'hD4,8'hD5,
    8'hD6,8'hD7,8'hD8,8'hD9,8'hDA,8'hE1,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,
    8'hE8,8'hE9,8'hEA,8'hF1,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,
    8'hFA,8'h11,8'h00,8'h02,8'h01,8'h02,8'h04,8'h04,8'h03,8'h04,8'h07,8'h05,
    8'h04,8'h04,8'h00,8'h01,8'h02,8'h77,8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,
    8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,8'h61,8'h71,8'h13,8'h22,
    8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'hA1,8'hB1,8'hC1,8'h09,8'h23,8'h33,
    8'h52,8'hF0,8'h15,8'h62,8'h72,8'hD1,8'h0A,8'h16,8'h24,8'h34,8'hE1,8'h25,
    8'hF1,8'h17,8'h18,8'h19,8'h1A,8'h26,8'h27,8'h28,8'h29,8'h2A,8'h35,8'h36,
    8'h37,8'h38,8'h39,8'h3A,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,
    8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5A,8'h63,8'h64,8'h65,8'h66,
    8'h67,8'h68,8'h69,8'h6A,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7A,
    8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8A,8'h92,8'h93,8'h94,
    8'h95,8'h96,8'h97,8'h98,8'h99,8'h9A,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,
    8'hA8,8'hA9,8'hAA,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBA,
    8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hCA,8'hD2,8'hD3,8'hD4,
    8'hD5,8'hD6,8'hD7,8'hD8,8'hD9,8'hDA,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,
    8'hE8,8'hE9,8'hEA,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'hFA
  };

  // Eight table bytes starting at byte 8*row, first byte in bits 7:0; zero past the table.
  function automatic logic [63:0] dht_word(input logic [9:0] row);
    logic [63:0] w;
    logic [12:0] idx;
    w = '0;
    for (int k = 0; k < OutBytes; k++) begin
      idx = {row, 3'b000} + 13'(k);
      if (idx < 13'(DhtRomLen)) begin
        w[8*k +: 8] = DHT_ROM[8*(DhtRomLen - 1 - int'(idx)) +: 8];
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mjpeg_huffman_table_inserter.sv =====
// Top level of the MJPEG-to-JPEG Huffman table inserter.
// An accepted input byte is registered in the command queue, then in the output register.
// Throughput: one byte in per cycle until the queue fills; one beat out per cycle unless stalled.
// Inserting the table costs ceil((TABLE_BYTES + 2) / BYTES_PER_RESULT) output beats (53 by default),
// as each beat carries at most BYTES_PER_RESULT bytes; the input keeps flowing until the queue fills.
// Reset: rst_n is synchronous and active low; it clears parser state, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none

module mjpeg_huffman_table_inserter #(
  parameter int TABLE_BYTES      = mhti_pkg::TableBytesDef,
  parameter int BYTES_PER_RESULT = mhti_pkg::BytesPerResultDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [63:0]        out_bytes,
  output logic [3:0]         out_count,
  output logic               out_last,
  output logic               out_frame_status
);
  import mhti_pkg::*;

  // The parser classifies each beat into one command: an optional table insertion
  // followed by at most two literal bytes. Beats that produce nothing and do not end
  // the frame never reach the queue, so the packer only sees real work.
  mhti_cmd_t cmd, head;
  logic      cmd_push, accept, q_not_empty, q_full, pop;

  // The input stalls only when the command queue is full.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  mhti_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  mhti_cmd_fifo #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && cmd_push),
    .push_data (cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // The packer funnels the table from aligned words, and the SOS marker bytes follow it
  // in the same command, so the table's tail shares its final beat with those bytes.
  mhti_back #(
    .TABLE_BYTES      (TABLE_BYTES),
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .head_valid       (q_not_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bytes        (out_bytes),
    .out_count        (out_count),
    .out_last         (out_last),
    .out_frame_status (out_frame_status)
  );

endmodule

`default_nettype wire

// ===== rtl/core/mhti_front.sv =====
// Front end: segment parser that turns each input byte into at most one queued command.
`timescale 1ns / 1ps
`default_nettype none

module mhti_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [7:0]            in_byte,
  input  wire logic                  in_last,
  output logic                       cmd_push,
  output mhti_pkg::mhti_cmd_t        cmd
);
  import mhti_pkg::*;

  typedef enum logic [9:0] {
    PH_START    = 10'b00_0000_0001,
    PH_MARK     = 10'b00_0000_0010,
    PH_LEN_HI   = 10'b00_0000_0100,
    PH_LEN_LO   = 10'b00_0000_1000,
    PH_SKIP     = 10'b00_0001_0000,
    PH_SOS_HI   = 10'b00_0010_0000,
    PH_SOS_LO   = 10'b00_0100_0000,
    PH_SOS_SKIP = 10'b00_1000_0000,
    PH_ENT      = 10'b01_0000_0000,
    PH_ENT_FF   = 10'b10_0000_0000
  } mhti_phase_t;

  mhti_phase_t phase_r, phase_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic        seen_r, seen_nxt;
  logic        err_r, err_nxt;
  logic        do_mark;
  logic [15:0] len_val;

  always_comb begin
    phase_nxt  = phase_r;
    skip_nxt   = skip_r;
    len_hi_nxt = len_hi_r;
    seen_nxt   = seen_r;
    err_nxt    = err_r;
    do_mark    = 1'b0;
    len_val    = {len_hi_r, in_byte};
    cmd        = '0;
    cmd.last   = in_last;

    if (!err_r) begin
      unique case (phase_r)
        PH_MARK: begin
          do_mark = 1'b1;
        end
        PH_LEN_HI, PH_SOS_HI: begin
          cmd.lit0   = in_byte;
          cmd.lit_n  = 2'd1;
          len_hi_nxt = in_byte;
          phase_nxt  = (phase_r == PH_SOS_HI) ? PH_SOS_LO : PH_LEN_LO;
        end
        PH_LEN_LO, PH_SOS_LO: begin
          cmd.lit0  = in_byte;
          cmd.lit_n = 2'd1;
          // A length field below two counts as two.
          skip_nxt  = (len_val < 16'd2) ? 16'd0 : len_val - 16'd2;
          if (skip_nxt == 16'd0) begin
            phase_nxt = (phase_r == PH_SOS_LO) ? PH_ENT : PH_START;
          end else begin
            phase_nxt = (phase_r == PH_SOS_LO) ? PH_SOS_SKIP : PH_SKIP;
          end
        end
        PH_SKIP, PH_SOS_SKIP: begin
          cmd.lit0  = in_byte;
          cmd.lit_n = 2'd1;
          skip_nxt  = skip_r - 16'd1;
          if (skip_nxt == 16'd0) begin
            phase_nxt = (phase_r == PH_SOS_SKIP) ? PH_ENT : PH_START;
          end
        end
        PH_ENT: begin
          if (in_byte == ByteFF) begin
            phase_nxt = PH_ENT_FF;
          end else begin
            cmd.lit0  = in_byte;
            cmd.lit_n = 2'd1;
          end
        end
        PH_ENT_FF: begin
          if (in_byte == ByteZero || (in_byte >= MarkRstLo && in_byte <= MarkSoi)) begin
            cmd.lit0  = ByteFF;
            cmd.lit1  = in_byte;
            cmd.lit_n = 2'd2;
            phase_nxt = PH_ENT;
          end else begin
            do_mark = 1'b1;
          end
        end
        default: begin
          if (in_byte == ByteFF) begin
            phase_nxt = PH_MARK;
          end else begin
            err_nxt = 1'b1;
          end
        end
      endcase
    end

    if (do_mark) begin
      cmd.lit0  = ByteFF;
      cmd.lit1  = in_byte;
      cmd.lit_n = 2'd2;
      if (in_byte == ByteFF || (in_byte >= MarkRstLo && in_byte <= MarkEoi)) begin
        phase_nxt = PH_START;
      end else if (in_byte == MarkSos) begin
        cmd.ins_table = !seen_r;
        phase_nxt     = PH_SOS_HI;
      end else begin
        if (in_byte == MarkDht) begin
          seen_nxt = 1'b1;
        end
        phase_nxt = PH_LEN_HI;
      end
    end

    // A frame that ends on a held FF flushes it; no byte was produced on that path.
    if (in_last && !err_nxt && (phase_nxt == PH_MARK || phase_nxt == PH_ENT_FF)) begin
      cmd.lit0  = ByteFF;
      cmd.lit_n = 2'd1;
    end

    cmd.err  = err_nxt;
    cmd_push = cmd.ins_table || (cmd.lit_n != 2'd0) || in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      skip_r   <= '0;
      len_hi_r <= '0;
      seen_r   <= 1'b0;
      err_r    <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        phase_r  <= PH_START;
        skip_r   <= '0;
        len_hi_r <= '0;
        seen_r   <= 1'b0;
        err_r    <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        skip_r   <= skip_nxt;
        len_hi_r <= len_hi_nxt;
        seen_r   <= seen_nxt;
        err_r    <= err_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mhti_cmd_fifo.sv =====
// Small command queue between the parser and the output packer.
`timescale 1ns / 1ps
`default_nettype none

module mhti_cmd_fifo #(
  parameter int DEPTH = mhti_pkg::QueueDepth
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  mhti_pkg::mhti_cmd_t      push_data,
  input  wire logic                pop,
  output mhti_pkg::mhti_cmd_t      head,
  output logic                     not_empty,
  output logic                     full
);
  import mhti_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mhti_cmd_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mhti_back.sv =====
// Back end: walks the head command up to BYTES_PER_RESULT bytes at a time and packs it into output beats.
`timescale 1ns / 1ps
`default_nettype none

module mhti_back #(
  parameter int TABLE_BYTES      = mhti_pkg::TableBytesDef,
  parameter int BYTES_PER_RESULT = mhti_pkg::BytesPerResultDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  mhti_pkg::mhti_cmd_t    head,
  input  wire logic              head_valid,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [63:0]            out_bytes,
  output logic [3:0]             out_count,
  output logic                   out_last,
  output logic                   out_frame_status
);
  import mhti_pkg::*;

  localparam int PW = $clog2(TABLE_BYTES + 3) + 1;

  logic [PW-1:0]  pos_r;
  logic [PW-1:0]  tins, len, rem, cnt, q, j;
  logic           fin, fire;
  logic [9:0]     row0, row1;
  logic [2:0]     off;
  logic [3:0]     sh;
  logic [127:0]   funnel;
  logic [63:0]    bytes_nxt;

  logic           out_valid_r;
  logic [63:0]    out_bytes_r;
  logic [3:0]     out_count_r;
  logic           out_last_r, out_status_r;

  always_comb begin
    tins   = head.ins_table ? PW'(TABLE_BYTES) : '0;
    len    = tins + PW'(head.lit_n);
    rem    = len - pos_r;
    fin    = (rem <= PW'(BYTES_PER_RESULT));
    cnt    = fin ? rem : PW'(BYTES_PER_RESULT);
    row0   = 10'(pos_r >> 3);
    row1   = row0 + 10'd1;
    off    = pos_r[2:0];
    funnel = {dht_word(row1), dht_word(row0)};
    bytes_nxt = '0;
    q  = '0;
    j  = '0;
    sh = '0;
    for (int k = 0; k < OutBytes; k++) begin
      q  = pos_r + PW'(k);
      j  = q - tins;
      sh = 4'(off) + 4'(k);
      if (k < BYTES_PER_RESULT && PW'(k) < cnt) begin
        if (q < tins) begin
          bytes_nxt[8*k +: 8] = funnel[8*sh +: 8];
        end else begin
          bytes_nxt[8*k +: 8] = (j == '0) ? head.lit0 : head.lit1;
        end
      end
    end
    fire = head_valid && (!out_valid_r || !out_stall);
    pop  = fire && fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        pos_r       <= fin ? '0 : pos_r + PW'(BYTES_PER_RESULT);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_bytes_r  <= bytes_nxt;
      out_count_r  <= 4'(cnt);
      out_last_r   <= head.last && fin;
      out_status_r <= head.err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bytes        = out_bytes_r;
  assign out_count        = out_count_r;
  assign out_last         = out_last_r;
  assign out_frame_status = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/core/mhti_checker.sv =====
// Port-level checker for the Huffman table inserter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mhti_checker #(
  parameter int BYTES_PER_RESULT = mhti_pkg::BytesPerResultDef
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_bytes,
  input wire logic [3:0]  out_count,
  input wire logic        out_last
);

  // A beat never carries more bytes than one result holds.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= 4'(BYTES_PER_RESULT))
    else $error("out_count above result width");

  // An empty beat only marks the end of a frame.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count == 4'd0 |-> out_last)
    else $error("empty beat without out_last");

  // Bytes above the count are zero.
  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bytes >> (8 * out_count)) == 64'd0)
    else $error("nonzero bytes above out_count");

  // A stalled beat stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bytes) && $stable(out_count))
    else $error("stalled beat changed");

endmodule

bind mjpeg_huffman_table_inserter mhti_checker #(
  .BYTES_PER_RESULT (BYTES_PER_RESULT)
) u_mhti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_bytes (out_bytes),
  .out_count (out_count),
  .out_last  (out_last)
);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the MJPEG Huffman table inserter: directed and random frames.
`timescale 1ns / 1ps

module tb;
  import mhti_pkg::*;

  localparam int TableLen     = TableBytesDef;
  localparam int BytesPerWord = BytesPerResultDef;
  localparam int HuffRomLen   = 420;
  localparam int CycleLimit   = 400000;
  localparam int DrainCycles  = 20;
  localparam int ItemsPerPhase = 85;

  // Standard DHT segment, first byte in the top bits, four bytes per word.
  localparam logic [8*HuffRomLen-1:0] STD_HUFF_TABLE = {
    32'hFFC401A2,32'h00000105,32'h01010101,32'h01010000,32'h00000000,32'h00000102,
    32'h03040506,32'h0708090A,32'h0B010003,32'h01010101,32'h01010101,32'h01000000,
    32'h00000001,32'h02030405,32'h06070809,32'h0A0B1000,32'h02010303,32'h02040305,
    32'h05040400,32'h00017D01,32'h02030004,32'h11051221,32'h31410613,32'h51610722,
    32'h71143281,32'h91A10823,32'h42B1C115,32'h52D1F024,32'h33627282,32'h090A1617,
    32'h18191A25,32'h26272829,32'h2A343536,32'h3738393A,32'h43444546,32'h4748494A,
    32'h53545556,32'h5758595A,32'h63646566,32'h6768696A,32'h73747576,32'h7778797A,
    32'h83848586,32'h8788898A,32'h92939495,32'h96979899,32'h9AA2A3A4,32'hA5A6A7A8,
    32'hA9AAB2B3,32'hB4B5B6B7,32'hB8B9BAC2,32'hC3C4C5C6,32'hC7C8C9CA,32'hD2D3D4D5,
    32'hD6D7D8D9,32'hDAE1E2E3,32'hE4E5E6E7,32'hE8E9EAF1,32'hF2F3F4F5,32'hF6F7F8F9,
    32'hFA110002,32'h01020404,32'h03040705,32'h04040001,32'h02770001,32'h02031104,
    32'h05213106,32'h12415107,32'h61711322,32'h32810814,32'h4291A1B1,32'hC1092333,
    32'h52F01562,32'h72D10A16,32'h2434E125,32'hF1171819,32'h1A262728,32'h292A3536,
    32'h3738393A,32'h43444546,32'h4748494A,32'h53545556,32'h5758595A,32'h63646566,
    32'h6768696A,32'h73747576,32'h7778797A,32'h82838485,32'h86878889,32'h8A929394,
    32'h95969798,32'h999AA2A3,32'hA4A5A6A7,32'hA8A9AAB2,32'hB3B4B5B6,32'hB7B8B9BA,
    32'hC2C3C4C5,32'hC6C7C8C9,32'hCAD2D3D4,32'hD5D6D7D8,32'hD9DAE2E3,32'hE4E5E6E7,
    32'hE8E9EAF2,32'hF3F4F5F6,32'hF7F8F9FA
  };

  typedef enum logic [3:0] {
    P_START, P_MARK, P_LEN_HI, P_LEN_LO, P_SKIP,
    P_SOS_HI, P_SOS_LO, P_SOS_SKIP, P_ENT, P_ENT_FF
  } parse_phase_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
    logic        status;
  } out_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_bytes;
  logic [3:0]  out_count;
  logic        out_last;
  logic        out_frame_status;

  idle_mode_t  idle_mode = IDLE_NONE;
  int          fail_count = 0;
  int unsigned cycle_count = 0;

  // Predictor state: the parser as the block should see the stream.
  parse_phase_t scan_phase;
  logic [15:0]  skip_left;
  logic [7:0]   len_high;
  logic         dht_seen;
  logic         bad_start;
  logic [7:0]   emitted_bytes[$];
  out_word_t    words_due[$];
  logic [7:0]   frame_bytes[$];

  mjpeg_huffman_table_inserter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bytes        (out_bytes),
    .out_count        (out_count),
    .out_last         (out_last),
    .out_frame_status (out_frame_status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [7:0] huff_byte(input int i);
    if (i < HuffRomLen) begin
      return STD_HUFF_TABLE[8*(HuffRomLen - 1 - i) +: 8];
    end
    return 8'h00;
  endfunction

  function automatic logic is_standalone(input logic [7:0] m);
    return m == ByteFF || (m >= MarkRstLo && m <= MarkEoi);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void clear_parser();
    scan_phase = P_START;
    skip_left  = '0;
    len_high   = '0;
    dht_seen   = 1'b0;
    bad_start  = 1'b0;
  endfunction

  // The held FF and its marker byte go out together; SOS gets the table first
  // unless the frame already carried its own DHT.
  function automatic void take_marker(input logic [7:0] m);
    if (is_standalone(m)) begin
      scan_phase = P_START;
    end else if (m == MarkSos) begin
      if (!dht_seen) begin
        for (int i = 0; i < TableLen; i++) begin
          emitted_bytes.push_back(huff_byte(i));
        end
      end
      scan_phase = P_SOS_HI;
    end else begin
      if (m == MarkDht) begin
        dht_seen = 1'b1;
      end
      scan_phase = P_LEN_HI;
    end
    emitted_bytes.push_back(ByteFF);
    emitted_bytes.push_back(m);
  endfunction

  function automatic void take_length_low(input logic [7:0] lo, input logic sos);
    logic [15:0] seg_len;
    seg_len = {len_high, lo};
    if (seg_len < 16'd2) begin
      seg_len = 16'd2;
    end
    skip_left = seg_len - 16'd2;
    if (skip_left == 16'd0) begin
      scan_phase = sos ? P_ENT : P_START;
    end else begin
      scan_phase = sos ? P_SOS_SKIP : P_SKIP;
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    case (scan_phase)
      P_MARK: begin
        take_marker(b);
      end
      P_LEN_HI, P_SOS_HI: begin
        emitted_bytes.push_back(b);
        len_high = b;
        scan_phase = (scan_phase == P_SOS_HI) ? P_SOS_LO : P_LEN_LO;
      end
      P_LEN_LO, P_SOS_LO: begin
        emitted_bytes.push_back(b);
        take_length_low(b, scan_phase == P_SOS_LO);
      end
      P_SKIP, P_SOS_SKIP: begin
        emitted_bytes.push_back(b);
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) begin
          scan_phase = (scan_phase == P_SOS_SKIP) ? P_ENT : P_START;
        end
      end
      P_ENT: begin
        if (b == ByteFF) begin
          scan_phase = P_ENT_FF;
        end else begin
          emitted_bytes.push_back(b);
        end
      end
      P_ENT_FF: begin
        // Stuffed zero and restart markers stay inside the scan.
        if (b == ByteZero || (b >= MarkRstLo && b <= MarkSoi)) begin
          emitted_bytes.push_back(ByteFF);
          emitted_bytes.push_back(b);
          scan_phase = P_ENT;
        end else begin
          take_marker(b);
        end
      end
      default: begin
        if (b == ByteFF) begin
          scan_phase = P_MARK;
        end else begin
          bad_start = 1'b1;
        end
      end
    endcase
  endfunction

  // Works out the output words one accepted input beat causes.
  function automatic void predict_rewrite(input logic [7:0] b, input logic l);
    int        nwords;
    int        pos;
    out_word_t w;
    emitted_bytes.delete();
    if (!bad_start) begin
      parse_byte(b);
    end
    if (l && !bad_start && (scan_phase == P_MARK || scan_phase == P_ENT_FF)) begin
      emitted_bytes.push_back(ByteFF);
    end
    nwords = (emitted_bytes.size() + BytesPerWord - 1) / BytesPerWord;
    if (nwords == 0 && l) begin
      nwords = 1;
    end
    pos = 0;
    for (int r = 0; r < nwords; r++) begin
      w.bytes = '0;
      w.count = '0;
      for (int k = 0; k < BytesPerWord && pos < emitted_bytes.size(); k++) begin
        w.bytes[8*k +: 8] = emitted_bytes[pos];
        pos++;
        w.count++;
      end
      w.last   = l && (r == nwords - 1);
      w.status = bad_start;
      words_due.push_back(w);
    end
    if (l) begin
      clear_parser();
    end
  endfunction

  // Result side: stall at random per phase and check every accepted beat.
  always @(posedge clk) begin : check_results
    out_word_t want;
    int        stall_pct;
    if (rst_n && out_valid && !out_stall) begin
      if (words_due.size() == 0) begin
        $error("unexpected beat: out_bytes %h out_count %0d", out_bytes, out_count);
        fail_count++;
      end else begin
        want = words_due.pop_front();
        if (out_bytes !== want.bytes) begin
          $error("out_bytes: expected %h, actual %h", want.bytes, out_bytes);
          fail_count++;
        end
        if (out_count !== want.count) begin
          $error("out_count: expected %0d, actual %0d", want.count, out_count);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0d, actual %0d", want.last, out_last);
          fail_count++;
        end
        if (out_frame_status !== want.status) begin
          $error("out_frame_status: expected %0d, actual %0d", want.status,
                 out_frame_status);
          fail_count++;
        end
      end
    end
    stall_pct = (idle_mode == IDLE_RECV) ? 53 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Offers one beat, holds it until accepted, then predicts its results.
  // Valid stays high on return so back-to-back beats need no second assignment.
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 53 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < gap_pct) begin
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_rewrite(b, l);
  endtask

  task automatic send_frame(inout int sent);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    sent += frame_bytes.size();
    frame_bytes.delete();
  endtask

  // The sender holds off until every predicted word has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (words_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_plain_marker();
    logic [7:0] m;
    m = rand_byte();
    while (is_standalone(m) || m == MarkSos || m == MarkDht) begin
      m = rand_byte();
    end
    return m;
  endfunction

  // Length field plus body; lengths 0 and 1 exercise the short-length rule.
  function automatic void add_segment_body();
    int seg_len;
    seg_len = $urandom_range(0, 6);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(seg_len[7:0]);
    for (int i = 2; i < seg_len; i++) begin
      frame_bytes.push_back(rand_byte());
    end
  endfunction

  function automatic void add_scan();
    int         n;
    logic [7:0] b;
    frame_bytes.push_back(ByteFF);
    frame_bytes.push_back(MarkSos);
    add_segment_body();
    n = $urandom_range(0, 16);
    for (int i = 0; i < n; i++) begin
      b = rand_byte();
      frame_bytes.push_back(b);
      if (b == ByteFF) begin
        if ($urandom_range(0, 1) == 0) begin
          frame_bytes.push_back(ByteZero);
        end else begin
          frame_bytes.push_back(8'($urandom_range(MarkRstLo, MarkSoi)));
        end
      end
    end
  endfunction

  // Mostly well-formed frames with random content; some noise, truncation and corruption.
  function automatic void build_random_frame();
    int n;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) frame_bytes.push_back(rand_byte());
      return;
    end
    frame_bytes.push_back(ByteFF);
    frame_bytes.push_back(MarkSoi);
    n = $urandom_range(0, 3);
    repeat (n) begin
      case ($urandom_range(0, 4))
        0: begin
          frame_bytes.push_back(ByteFF);
          frame_bytes.push_back(ByteFF);
        end
        1: begin
          frame_bytes.push_back(ByteFF);
          frame_bytes.push_back(8'($urandom_range(MarkRstLo, MarkEoi)));
        end
        2: begin
          frame_bytes.push_back(ByteFF);
          frame_bytes.push_back(MarkDht);
          add_segment_body();
        end
        default: begin
          frame_bytes.push_back(ByteFF);
          frame_bytes.push_back(pick_plain_marker());
          add_segment_body();
        end
      endcase
    end
    if ($urandom_range(0, 4) != 0) begin
      add_scan();
      if ($urandom_range(0, 3) == 0) begin
        add_scan();
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      // A segment with a full 16-bit length, cut short by the end of the frame.
      frame_bytes.push_back(ByteFF);
      frame_bytes.push_back(pick_plain_marker());
      frame_bytes.push_back(rand_byte());
      frame_bytes.push_back(rand_byte());
      n = $urandom_range(0, 4);
      repeat (n) frame_bytes.push_back(rand_byte());
    end else begin
      frame_bytes.push_back(ByteFF);
      frame_bytes.push_back(MarkEoi);
    end
    if ($urandom_range(0, 6) == 0) begin
      frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = rand_byte();
    end
  endfunction

  // Padding pair, standalone end marker, then a bad segment start on the last byte.
  task automatic test_markers_and_bad_start();
    int sent;
    sent = 0;
    frame_bytes = '{ByteFF, ByteFF, ByteFF, MarkEoi, ByteZero};
    send_frame(sent);
  endtask

  // A frame that ends on the FF opening a segment sends that FF alone.
  task automatic test_held_marker_ff();
    int sent;
    sent = 0;
    frame_bytes = '{ByteFF};
    send_frame(sent);
  endtask

  // Scan without a DHT: table insertion, short header length, stuffing, a restart
  // marker, a DHT ending the scan, and a frame end inside its length field.
  task automatic test_scan_table_insert();
    int sent;
    sent = 0;
    frame_bytes = '{ByteFF, MarkSos, 8'h00, 8'h01, 8'h12, ByteFF, ByteZero,
                    ByteFF, MarkRstLo + 8'd3, ByteFF, MarkDht, 8'h00};
    send_frame(sent);
  endtask

  // A DHT ahead of the scan suppresses insertion; the frame ends in entropy on FF.
  task automatic test_scan_after_dht();
    int sent;
    sent = 0;
    frame_bytes = '{ByteFF, MarkDht, 8'h00, 8'h00, ByteFF, MarkSos, 8'h00, 8'h02,
                    ByteFF};
    send_frame(sent);
  endtask

  task automatic test_random_frames(input idle_mode_t mode, input int items);
    int sent;
    sent = 0;
    idle_mode = mode;
    while (sent < items) begin
      build_random_frame();
      send_frame(sent);
    end
    drain_results();
  endtask

  initial begin
    clear_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_markers_and_bad_start();
    test_held_marker_ff();
    test_scan_table_insert();
    test_scan_after_dht();
    drain_results();

    test_random_frames(IDLE_NONE, ItemsPerPhase);
    test_random_frames(IDLE_SEND, ItemsPerPhase);
    test_random_frames(IDLE_RECV, ItemsPerPhase);
    test_random_frames(IDLE_BOTH, ItemsPerPhase);

    idle_mode = IDLE_NONE;
    drain_results();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
